@@ sv/sas_pkg.sv @@
// sas_pkg: shared types, constants and lookup functions for the sequence
// alphabet sanitizer. No dependencies.
package sas_pkg;

  // alphabet selector codes
  localparam logic [1:0] MODE_DNA     = 2'd1;
  localparam logic [1:0] MODE_RNA     = 2'd2;
  localparam logic [1:0] MODE_RESET   = MODE_DNA;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_ALPHABET_MODE   = 2'd0,
    REG_REPLACE_CHAR    = 2'd1,
    REG_FAIL_ON_INVALID = 2'd2,
    REG_UNUSED          = 2'd3
  } cfg_idx_t;

  // character constants
  localparam logic [7:0] CH_UPPER_U = 8'h55;  // 'U'
  localparam logic [7:0] CH_UPPER_T = 8'h54;  // 'T'
  localparam logic [7:0] CH_UPPER_J = 8'h4A;  // 'J'
  localparam logic [7:0] CH_LOWER_J = 8'h6A;  // 'j'
  localparam logic [7:0] CH_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;  // 'z'
  localparam logic [7:0] CH_DASH    = 8'h2D;  // '-'
  localparam logic [7:0] CH_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CH_DOT     = 8'h2E;  // '.'
  localparam logic [7:0] CH_STAR    = 8'h2A;  // '*'
  localparam logic [7:0] CASE_DELTA = 8'd32;

  // live configuration
  typedef struct packed {
    logic [1:0] alphabet_mode;
    logic [7:0] replace_char;
    logic       fail_on_invalid;
  } cfg_t;

  // fold lowercase ascii letters to uppercase
  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      r = c - CASE_DELTA;
    end
    return r;
  endfunction

  // iupac nucleotide letters shared by dna and rna (no t/u)
  function automatic logic is_nuc_common(input logic [7:0] up);
    return up inside {"A", "C", "G", "N", "M", "R", "W", "S", "Y", "K",
                      "V", "H", "D", "B"};
  endfunction

  // protein one-letter codes, uppercase
  function automatic logic is_aa_upper(input logic [7:0] up);
    return up inside {"A", "R", "N", "D", "C", "Q", "E", "G", "H", "I",
                      "L", "K", "M", "F", "P", "S", "T", "W", "Y", "V",
                      "U", "O", "B", "Z", "X"};
  endfunction

  // gap and marker symbols valid in every alphabet
  function automatic logic is_gap_mark(input logic [7:0] c);
    return c inside {CH_DASH, CH_PLUS, CH_DOT};
  endfunction

endpackage

@@ sv/sas_cfg_regs.sv @@
// sas_cfg_regs: configuration register file for the alphabet sanitizer.
// Depends on sas_pkg.
module sas_cfg_regs import sas_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        REG_ALPHABET_MODE:   cfg_nxt.alphabet_mode   = cfg_data[1:0];
        REG_REPLACE_CHAR:    cfg_nxt.replace_char    = cfg_data;
        REG_FAIL_ON_INVALID: cfg_nxt.fail_on_invalid = cfg_data[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alphabet_mode   <= MODE_RESET;
      cfg_r.replace_char    <= '0;
      cfg_r.fail_on_invalid <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/sas_classify.sv @@
// sas_classify: combinational check of one character against the selected
// alphabet, with conversion, replacement and error flag. Depends on sas_pkg.
module sas_classify import sas_pkg::*; (
  input  cfg_t       cfg,
  input  logic [7:0] char_in,
  output logic [7:0] char_out,
  output logic       kept,
  output logic       invalid_error
);

  logic [7:0] up;
  logic [7:0] keep_ch;
  logic [7:0] conv_ch;
  logic       is_nuc_mode;
  logic       valid_ch;
  logic [7:0] res_ch;

  assign up          = fold_upper(char_in);
  assign is_nuc_mode = (cfg.alphabet_mode == MODE_DNA) || (cfg.alphabet_mode == MODE_RNA);
  assign keep_ch     = (cfg.alphabet_mode == MODE_DNA) ? CH_UPPER_T : CH_UPPER_U;
  assign conv_ch     = (cfg.alphabet_mode == MODE_DNA) ? CH_UPPER_U : CH_UPPER_T;

  // alphabet lookup
  always_comb begin
    valid_ch = 1'b0;
    res_ch   = char_in;
    if (is_nuc_mode) begin
      if (up == conv_ch) begin
        valid_ch = 1'b1;
        res_ch   = keep_ch;
      end else if (is_gap_mark(char_in) || up == keep_ch || is_nuc_common(up)) begin
        valid_ch = 1'b1;
      end
    end else begin
      // protein: lowercase j folds, uppercase J does not pass
      if (is_gap_mark(char_in) || char_in == CH_STAR) begin
        valid_ch = 1'b1;
      end else if (char_in == CH_LOWER_J) begin
        valid_ch = 1'b1;
        res_ch   = CH_UPPER_J;
      end else if (is_aa_upper(up)) begin
        valid_ch = 1'b1;
        res_ch   = up;
      end
    end
  end

  // invalid handling: fail, then replace, then drop
  always_comb begin
    char_out      = '0;
    kept          = 1'b0;
    invalid_error = 1'b0;
    if (valid_ch) begin
      char_out = res_ch;
      kept     = 1'b1;
    end else if (cfg.fail_on_invalid) begin
      invalid_error = 1'b1;
    end else if (cfg.replace_char != '0) begin
      char_out = cfg.replace_char;
      kept     = 1'b1;
    end
  end

endmodule

@@ sv/sequence_alphabet_sanitizer.sv @@
// sequence_alphabet_sanitizer: checks a stream of sequence characters
// against a DNA, RNA or protein alphabet, one character per transfer.
// Result path: input register, then result register. Throughput: one
// character per cycle unless out_ready stalls the output, set by the single
// lookup stage between the two registers. Reset clears the valid flags and
// loads the config registers with DNA mode, no replacement and failing off.
module sequence_alphabet_sanitizer import sas_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // configuration port
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_end_of_sequence,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_kept,
  output logic       out_invalid_error,
  output logic       out_end_of_sequence_out
);

  cfg_t       cfg;
  logic       s1_vld_r;
  logic [7:0] s1_char_r;
  logic       s1_eos_r;
  logic       out_vld_r;
  logic [7:0] out_char_r;
  logic       out_kept_r;
  logic       out_err_r;
  logic       out_eos_r;
  logic       s1_adv;
  logic [7:0] cls_char;
  logic       cls_kept;
  logic       cls_err;

  sas_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage handshake: each register takes data when empty or draining
  assign s1_adv   = !out_vld_r || out_ready;
  assign in_ready = !s1_vld_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_char;
      s1_eos_r  <= in_end_of_sequence;
    end
  end

  sas_classify u_cls (
    .cfg           (cfg),
    .char_in       (s1_char_r),
    .char_out      (cls_char),
    .kept          (cls_kept),
    .invalid_error (cls_err)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_vld_r) begin
      out_char_r <= cls_char;
      out_kept_r <= cls_kept;
      out_err_r  <= cls_err;
      out_eos_r  <= s1_eos_r;
    end
  end

  assign out_valid               = out_vld_r;
  assign out_char                = out_char_r;
  assign out_kept                = out_kept_r;
  assign out_invalid_error       = out_err_r;
  assign out_end_of_sequence_out = out_eos_r;

endmodule
